// ===== hdl/ael_pkg.sv =====
// shared types and constants for the arithmetic expression lexer
// character codes, token kinds, scanner modes and the beat structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ael_pkg;

  localparam int unsigned NumberWidth = 32;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharLparen = 8'h28;
  localparam logic [7:0] CharRparen = 8'h29;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [3:0] {
    KindNumber   = 4'd0,
    KindPlus     = 4'd1,
    KindMinus    = 4'd2,
    KindMul      = 4'd3,
    KindDiv      = 4'd4,
    KindLparen   = 4'd5,
    KindRparen   = 4'd6,
    KindComment  = 4'd7,
    KindInvalid  = 4'd8,
    KindEnd      = 4'd9,
    KindUnclosed = 4'd10,
    KindOverflow = 4'd11
  } token_kind_e;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeMinus   = 2'd1,
    ModeNumber  = 2'd2,
    ModeComment = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } lex_in_t;

  typedef struct packed {
    token_kind_e                    token_kind;
    logic signed [NumberWidth-1:0]  number_value;
    logic                           last_of_run;
  } lex_out_t;

  // raw token as it leaves the scanner, number value still unsigned
  typedef struct packed {
    token_kind_e kind;
    logic        ovf;
    logic        neg;
    logic        last;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ael_scan.sv =====
// front end: classifies each text byte and tracks the number being read
// produces up to two raw tokens per byte
// depends on ael_pkg
`timescale 1ns / 1ps
`default_nettype none

module ael_scan #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ael_pkg::lex_in_t       in_data_i,
  input  wire logic                   accept_i,
  output ael_pkg::tok_ctl_t           tok0_o,
  output logic [VALUE_WIDTH-1:0]      tok0_mag_o,
  output logic                        tok0_valid_o,
  output ael_pkg::tok_ctl_t           tok1_o,
  output logic                        tok1_valid_o
);
  import ael_pkg::*;

  localparam int unsigned MulWidth = VALUE_WIDTH + 4;
  localparam logic [MulWidth-1:0] Limit = MulWidth'(1) << (VALUE_WIDTH - 1);

  scan_mode_e             mode_q, mode_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   ovf_q, ovf_d;

  logic [7:0]    c;
  logic          is_end, is_digit, is_space, is_hash;
  logic [3:0]    digit;
  logic [MulWidth-1:0] mag_ext, ten_mag;

  logic          idle_emit;
  token_kind_e   idle_kind;
  scan_mode_e    idle_mode;

  token_kind_e   k0, k1;
  logic          v0, v1;

  assign c        = in_data_i.text_byte;
  assign is_end   = in_data_i.end_of_text || (c == CharNul);
  assign is_digit = c inside {[CharZero:CharNine]};
  assign is_space = c inside {CharSpace, [CharTab:CharCr]};
  assign is_hash  = (c == CharHash);
  assign digit    = c[3:0];

  // mag*10 + digit, overflow when it passes the negative limit
  assign mag_ext = MulWidth'(mag_q);
  assign ten_mag = (mag_ext << 3) + (mag_ext << 1) + MulWidth'(digit);

  // what a byte does when no token is pending
  always_comb begin
    idle_emit = 1'b1;
    idle_kind = KindInvalid;
    idle_mode = ModeIdle;
    if (is_space) begin
      idle_emit = 1'b0;
    end else if (is_digit) begin
      idle_emit = 1'b0;
      idle_mode = ModeNumber;
    end else begin
      case (c)
        CharMinus: begin
          idle_emit = 1'b0;
          idle_mode = ModeMinus;
        end
        CharHash: begin
          idle_emit = 1'b0;
          idle_mode = ModeComment;
        end
        CharPlus:   idle_kind = KindPlus;
        CharStar:   idle_kind = KindMul;
        CharSlash:  idle_kind = KindDiv;
        CharLparen: idle_kind = KindLparen;
        CharRparen: idle_kind = KindRparen;
        default:    idle_kind = KindInvalid;
      endcase
    end
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (is_end) begin
      mode_d = ModeIdle;
      mag_d  = '0;
      neg_d  = 1'b0;
      ovf_d  = 1'b0;
    end else begin
      case (mode_q)
        ModeMinus: begin
          if (is_digit) begin
            mode_d = ModeNumber;
            mag_d  = VALUE_WIDTH'(digit);
            neg_d  = 1'b1;
            ovf_d  = 1'b0;
          end else begin
            mode_d = idle_mode;
            mag_d  = '0;
            neg_d  = 1'b0;
            ovf_d  = 1'b0;
          end
        end
        ModeNumber: begin
          if (is_digit) begin
            if (!ovf_q) begin
              if (ten_mag > Limit) begin
                ovf_d = 1'b1;
              end else begin
                mag_d = ten_mag[VALUE_WIDTH-1:0];
              end
            end
          end else begin
            mode_d = idle_mode;
            mag_d  = '0;
            neg_d  = 1'b0;
            ovf_d  = 1'b0;
          end
        end
        ModeComment: begin
          if (is_hash) begin
            mode_d = ModeIdle;
          end
        end
        default: begin
          mode_d = idle_mode;
          if (is_digit) begin
            mag_d = VALUE_WIDTH'(digit);
            neg_d = 1'b0;
            ovf_d = 1'b0;
          end
        end
      endcase
    end
  end

  // tokens caused by this byte, first one always in slot 0
  always_comb begin
    v0 = 1'b0;
    k0 = KindEnd;
    v1 = 1'b0;
    k1 = KindEnd;
    if (is_end) begin
      v0 = 1'b1;
      case (mode_q)
        ModeMinus: begin
          k0 = KindMinus;
          v1 = 1'b1;
        end
        ModeNumber: begin
          k0 = KindNumber;
          v1 = 1'b1;
        end
        ModeComment: k0 = KindUnclosed;
        default:     k0 = KindEnd;
      endcase
    end else begin
      case (mode_q)
        ModeMinus: begin
          if (!is_digit) begin
            v0 = 1'b1;
            k0 = KindMinus;
            v1 = idle_emit;
            k1 = idle_kind;
          end
        end
        ModeNumber: begin
          if (!is_digit) begin
            v0 = 1'b1;
            k0 = KindNumber;
            v1 = idle_emit;
            k1 = idle_kind;
          end
        end
        ModeComment: begin
          v0 = is_hash;
          k0 = KindComment;
        end
        default: begin
          v0 = idle_emit;
          k0 = idle_kind;
        end
      endcase
    end
  end

  assign tok0_valid_o = v0;
  assign tok0_o.kind  = k0;
  assign tok0_o.ovf   = ovf_q;
  assign tok0_o.neg   = neg_q;
  assign tok0_o.last  = !v1;
  assign tok0_mag_o   = mag_q;

  assign tok1_valid_o = v1;
  assign tok1_o.kind  = k1;
  assign tok1_o.ovf   = 1'b0;
  assign tok1_o.neg   = 1'b0;
  assign tok1_o.last  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      mag_q  <= '0;
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ael_queue.sv =====
// short token queue between scanner and emitter
// takes up to two entries per cycle, gives one
// depends on ael_pkg only through its users
`timescale 1ns / 1ps
`default_nettype none

module ael_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push0_i,
  input  wire logic [Width-1:0] data0_i,
  input  wire logic             push1_i,
  input  wire logic [Width-1:0] data1_i,
  input  wire logic             pop_i,
  output logic                  head_valid_o,
  output logic [Width-1:0]      head_o,
  output logic                  room2_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0]  count_q, count_d;

  assign wr_next      = wr_q + PtrW'(1);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_q];
  assign room2_o      = (count_q <= CntW'(Depth - 2));

  always_comb begin
    wr_d    = wr_q + PtrW'(push0_i) + PtrW'(push1_i);
    rd_d    = rd_q + PtrW'(pop_i);
    count_d = count_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_next] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("token queue count out of range");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second slot pushed without first");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty token queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0_i || pop_i) |=> (count_q == $past(count_d)))
    else $error("queue count lost an update");

endmodule

`default_nettype wire

// ===== hdl/ael_emit.sv =====
// back end: turns raw tokens into signed number beats with overflow check
// holds the output register
// depends on ael_pkg
`timescale 1ns / 1ps
`default_nettype none

module ael_emit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   head_valid_i,
  input  wire ael_pkg::tok_ctl_t      head_ctl_i,
  input  wire logic [VALUE_WIDTH-1:0] head_mag_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output ael_pkg::lex_out_t           out_data_o
);
  import ael_pkg::*;

  logic                         valid_q, valid_d;
  lex_out_t                     data_q, data_d;
  logic [VALUE_WIDTH:0]         sval;
  logic signed [NumberWidth-1:0] value32;
  logic                         too_big;

  assign sval    = head_ctl_i.neg ? -{1'b0, head_mag_i} : {1'b0, head_mag_i};
  assign too_big = head_ctl_i.ovf || (!head_ctl_i.neg && head_mag_i[VALUE_WIDTH-1]);

  if (VALUE_WIDTH + 1 >= NumberWidth) begin : g_trunc
    assign value32 = sval[NumberWidth-1:0];
  end else begin : g_sext
    assign value32 = {{(NumberWidth - VALUE_WIDTH - 1){sval[VALUE_WIDTH]}}, sval};
  end

  assign pop_o = head_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (pop_o) begin
      valid_d             = 1'b1;
      data_d.token_kind   = head_ctl_i.kind;
      data_d.number_value = '0;
      data_d.last_of_run  = head_ctl_i.last;
      if (head_ctl_i.kind == KindNumber) begin
        if (too_big) begin
          data_d.token_kind = KindOverflow;
        end else begin
          data_d.number_value = value32;
        end
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== hdl/arithmetic_expression_lexer.sv =====
// top level of the arithmetic expression lexer
// ties scanner, token queue and emitter together
// depends on ael_pkg, ael_scan, ael_queue, ael_emit
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for arithmetic text: one byte per input beat, tokens out
// (signed decimal numbers, + - * / ( ), comments #...#, invalid bytes, end).
// A byte 0 or a beat with end_of_text set closes the text and flushes any
// held minus or number before the end (or unclosed comment) token. Bytes
// stream in at one per cycle while the queue has room for two entries; a
// byte that yields two tokens (a held minus or a finished number followed by
// an operator, or a flush at end of text) leaves the single output port as
// two beats. The scanner pushes into a four-entry token queue and is ready
// only while the queue has room for two entries, which sets the input stall.
// Tokens pass through the queue, then the output register, on their way out.
// number_value is zero for every token kind except number.
module arithmetic_expression_lexer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ael_pkg::lex_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ael_pkg::lex_out_t      out_data_o
);
  import ael_pkg::*;

  localparam int unsigned CtlW   = $bits(tok_ctl_t);
  localparam int unsigned EntryW = CtlW + VALUE_WIDTH;

  // front side
  logic                   accept;
  tok_ctl_t               tok0, tok1;
  logic [VALUE_WIDTH-1:0] tok0_mag;
  logic                   tok0_valid, tok1_valid;

  // queue
  logic                   room2;
  logic [EntryW-1:0]      head;
  logic                   head_valid;
  logic                   pop;

  // back side view of the queue head
  tok_ctl_t               head_ctl;
  logic [VALUE_WIDTH-1:0] head_mag;

  // ready depends only on queue fill, never on the output handshake directly
  assign in_ready_o = room2;
  assign accept     = in_valid_i && room2;

  ael_scan #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .accept_i     (accept),
    .tok0_o       (tok0),
    .tok0_mag_o   (tok0_mag),
    .tok0_valid_o (tok0_valid),
    .tok1_o       (tok1),
    .tok1_valid_o (tok1_valid)
  );

  // second slot never carries a number, so its magnitude field is zero
  ael_queue #(
    .Width (EntryW),
    .Depth (4)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push0_i      (accept && tok0_valid),
    .data0_i      ({tok0, tok0_mag}),
    .push1_i      (accept && tok1_valid),
    .data1_i      ({tok1, {VALUE_WIDTH{1'b0}}}),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .room2_o      (room2)
  );

  assign head_ctl = tok_ctl_t'(head[EntryW-1:VALUE_WIDTH]);
  assign head_mag = head[VALUE_WIDTH-1:0];

  ael_emit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ctl_i   (head_ctl),
    .head_mag_i   (head_mag),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // an end-of-text beat always produces a token that closes its run
  a_end_makes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.end_of_text || in_data_i.text_byte == CharNul))
      |-> tok0_valid)
    else $error("end of text without a token");

  // a two-token beat marks only its second token as last
  a_last_marking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok0_valid && tok1_valid) |-> (!tok0.last && tok1.last))
    else $error("last flag on wrong token of a pair");

  // non-number tokens leave the block with a zero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.token_kind != KindNumber)
      |-> (out_data_o.number_value == '0))
    else $error("nonzero value on non-number token");

endmodule

`default_nettype wire
